[rtl/lrg_pkg.sv]
package lrg_pkg;

	// generator constants
	localparam int SEED_W  = 31;
	localparam int MULT_W  = 29;
	localparam int PROD_W  = SEED_W + MULT_W;
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 2;

	localparam logic [SEED_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
	localparam logic [MULT_W-1:0] LEHMER_MULT = 29'd397204094;

	// one division cell per bit of the seed
	localparam int NUM_CELLS = SEED_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_DRAW_INT  = 2'd0,
		CMD_DRAW_FRAC = 2'd1,
		CMD_LOAD      = 2'd2,
		CMD_UNUSED    = 2'd3
	} lrg_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_FOLD
	} lrg_state_t;

	// payload that moves from cell to cell
	typedef struct packed {
		logic              frac;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] rem;
		logic [SEED_W-1:0] dividend;
	} lrg_work_t;

endpackage

[rtl/lrg_mod_cell.sv]
module lrg_mod_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  lrg_pkg::lrg_work_t in_work,
	output logic              out_valid,
	output lrg_pkg::lrg_work_t out_work
);
	import lrg_pkg::*;

	logic [DATA_W:0]   partial;
	logic [DATA_W+1:0] diff;
	lrg_work_t         next_work;

	// one restoring step: bring in the next dividend bit, subtract if it fits (fraction work keeps its rem)
	always_comb begin
		partial   = {in_work.rem, in_work.dividend[SEED_W-1]};
		diff      = {1'b0, partial} - {2'b00, in_work.divisor};
		next_work = in_work;
		next_work.dividend = {in_work.dividend[SEED_W-2:0], 1'b0};
		if (!in_work.frac) begin
			if (!diff[DATA_W+1]) begin
				next_work.rem = diff[DATA_W-1:0];
			end else begin
				next_work.rem = partial[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_work <= next_work;
		end
	end

	// partial remainder stays below a nonzero divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_work.frac && out_work.divisor != '0)
			|-> (out_work.rem < out_work.divisor))
		else $error("partial remainder not below divisor");

endmodule

[rtl/lrg_seed_unit.sv]
module lrg_seed_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [lrg_pkg::CMD_W-1:0]    command,
	input  logic [lrg_pkg::DATA_W-1:0]   range_limit,
	input  logic [lrg_pkg::DATA_W-1:0]   seed_value,
	input  logic                         en,
	output logic                         inj_valid,
	output lrg_pkg::lrg_work_t           inj_work
);
	import lrg_pkg::*;

	lrg_state_t          state_q, state_nxt;
	logic [SEED_W-1:0]   seed_q;
	logic [PROD_W-1:0]   prod_s1;
	logic                frac_q;
	logic [DATA_W-1:0]   range_q;
	logic                accept;
	logic                start_draw;
	logic                load_seed;
	logic [DATA_W-1:0]   fold_sum;
	logic [SEED_W-1:0]   new_seed;
	logic [SEED_W-1:0]   load_red;
	logic [DATA_W-1:0]   seed_x2;
	logic [DATA_W-1:0]   frac_val;

	// value mod 2^31-1 for any 32-bit value
	function automatic logic [SEED_W-1:0] mersenne_reduce(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		t = {1'b0, v[SEED_W-1:0]} + {{(DATA_W-1){1'b0}}, v[DATA_W-1]};
		if (t >= {1'b0, LEHMER_MOD}) begin
			t = t - {1'b0, LEHMER_MOD};
		end
		return t[SEED_W-1:0];
	endfunction

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		start_draw = 1'b0;
		load_seed  = 1'b0;
		unique case (lrg_cmd_t'(command))
			CMD_DRAW_INT, CMD_DRAW_FRAC: start_draw = accept;
			CMD_LOAD:                    load_seed  = accept;
			default:                     ;
		endcase
	end

	// fold the 60-bit product: high part added to low part, then a final mod 2^31-1 reduction
	assign fold_sum = {1'b0, prod_s1[SEED_W-1:0]}
		+ {{(DATA_W-MULT_W){1'b0}}, prod_s1[PROD_W-1:SEED_W]};
	assign new_seed = mersenne_reduce(fold_sum);
	assign load_red = mersenne_reduce(seed_value);

	// seed*2^32/M = 2*seed + (2*seed >= M) since 2^32 = 2M + 2
	assign seed_x2  = {new_seed, 1'b0};
	assign frac_val = seed_x2 + {{(DATA_W-1){1'b0}}, (seed_x2 >= {1'b0, LEHMER_MOD})};

	always_comb begin
		state_nxt = state_q;
		inj_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_draw) begin
					state_nxt = ST_FOLD;
				end
			end
			ST_FOLD: begin
				inj_valid = 1'b1;
				if (en) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		inj_work.frac     = frac_q;
		inj_work.divisor  = range_q;
		inj_work.rem      = frac_q ? frac_val : '0;
		inj_work.dividend = new_seed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (load_seed) begin
				seed_q <= load_red;
			end else if (state_q == ST_FOLD && en) begin
				seed_q <= new_seed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_draw) begin
			prod_s1 <= {{MULT_W{1'b0}}, seed_q} * {{SEED_W{1'b0}}, LEHMER_MULT};
			frac_q  <= (lrg_cmd_t'(command) == CMD_DRAW_FRAC);
			range_q <= range_limit;
		end
	end

	a_seed_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		seed_q != LEHMER_MOD)
		else $error("seed not reduced");

	a_fold_follows_draw: assert property (@(posedge clk) disable iff (!arst_n)
		start_draw |=> (state_q == ST_FOLD))
		else $error("draw did not enter fold");

endmodule

[rtl/lehmer_random_generator_core.sv]
// Lehmer generator, multiplier 397204094, modulus 2^31-1. command 0 advances the
// seed and returns seed mod range_limit (0 when range_limit is 0); command 1
// advances the seed and returns the unsigned 0.32 fraction floor(seed*2^32/M);
// command 2 loads seed_value mod 2^31-1 and gives no transfer on the result side;
// command 3 is dropped. The seed resets to 0 and a zero seed stays 0, so load a
// nonzero seed before drawing. A draw occupies the seed unit for a registered
// 31x29 multiply, then the Mersenne fold, which holds while the result side
// stalls; no new command is taken until the fold is done, and loads are taken
// every cycle while the unit is idle. The remainder is then worked out by a row
// of 31 restoring-division cells, one dividend bit per cell per cycle while the
// result side does not stall; each result passes from the fold through the cells
// into the output register, from which it can transfer. A stall on the result
// side freezes the whole cell row.
module lehmer_random_generator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [lrg_pkg::CMD_W-1:0]  command,
	input  logic [lrg_pkg::DATA_W-1:0] range_limit,
	input  logic [lrg_pkg::DATA_W-1:0] seed_value,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [lrg_pkg::DATA_W-1:0] value
);
	import lrg_pkg::*;

	// chain tap 0 is the injection from the seed unit, tap NUM_CELLS the row end
	logic      cell_valid [NUM_CELLS+1];
	lrg_work_t cell_work  [NUM_CELLS+1];
	logic      en;
	logic      res_valid_q;
	logic [DATA_W-1:0] value_q;

	// the row moves whenever the output register can take what falls off its end
	assign en = !res_valid_q || !res_stall;

	lrg_seed_unit u_seed (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.range_limit (range_limit),
		.seed_value  (seed_value),
		.en          (en),
		.inj_valid   (cell_valid[0]),
		.inj_work    (cell_work[0])
	);

	// row of division cells, each handing its partial remainder to the next
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lrg_mod_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[i]),
			.in_work   (cell_work[i]),
			.out_valid (cell_valid[i+1]),
			.out_work  (cell_work[i+1])
		);
	end

	// output register: fraction passes as is, zero range gives 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= cell_valid[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cell_work[NUM_CELLS].frac) begin
				value_q <= cell_work[NUM_CELLS].rem;
			end else if (cell_work[NUM_CELLS].divisor == '0) begin
				value_q <= '0;
			end else begin
				value_q <= cell_work[NUM_CELLS].rem;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign value     = value_q;

	// a held transfer must freeze the end of the cell row
	a_row_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> $stable(cell_valid[NUM_CELLS]))
		else $error("cell row moved while result held");

endmodule

[verif/lehmer_random_generator_core_tb.sv]
`timescale 1ns / 1ps

module lehmer_random_generator_core_tb;

	import lrg_pkg::*;

	// generator arithmetic, kept apart from the block's own constants
	localparam longint unsigned GEN_MODULUS    = 64'd2147483647;
	localparam longint unsigned GEN_MULTIPLIER = 64'd397204094;

	// drain allowance after the last expected transfer
	localparam int DRAIN_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [CMD_W-1:0]   command;
	logic [DATA_W-1:0]  range_limit;
	logic [DATA_W-1:0]  seed_value;
	logic               res_valid;
	logic               res_stall;
	logic [DATA_W-1:0]  value;

	// predictor state: current seed, always below 2^31-1
	logic [30:0]        lehmer_seed;
	// draw values still owed by the block, oldest first
	logic [DATA_W-1:0]  expected_values[$];
	int unsigned        mismatch_count;

	// pacing switches, flipped between stretches of traffic
	bit                 sender_idle_en;
	bit                 receiver_idle_en;

	lehmer_random_generator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.range_limit (range_limit),
		.seed_value  (seed_value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.value       (value)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// idle length: mostly none, often short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one step of the recurrence using the full product
	function automatic logic [30:0] lehmer_advance(input logic [30:0] cur);
		longint unsigned product;
		product = longint'(cur) * GEN_MULTIPLIER;
		return 31'(product % GEN_MODULUS);
	endfunction

	// update the predicted seed for an accepted command and queue any draw value
	task automatic predict_command(input lrg_cmd_t op, input logic [31:0] limit,
			input logic [31:0] new_seed);
		longint unsigned scaled;
		case (op)
			CMD_DRAW_INT: begin
				lehmer_seed = lehmer_advance(lehmer_seed);
				if (limit == 32'd0)
					expected_values.push_back(32'd0);
				else
					expected_values.push_back(32'({1'b0, lehmer_seed} % limit));
			end
			CMD_DRAW_FRAC: begin
				lehmer_seed = lehmer_advance(lehmer_seed);
				// seed * 2^32 / modulus, truncated: unsigned 0.32 fraction
				scaled = {1'b0, lehmer_seed, 32'h0} / GEN_MODULUS;
				expected_values.push_back(scaled[31:0]);
			end
			CMD_LOAD:
				lehmer_seed = 31'(longint'(new_seed) % GEN_MODULUS);
			default: ;
		endcase
	endtask

	// drive one command, hold it until the transfer, then predict
	task automatic send_command(input lrg_cmd_t op, input logic [31:0] limit,
			input logic [31:0] new_seed);
		int unsigned gap;
		gap = sender_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid   <= 1'b1;
		command     <= op;
		range_limit <= limit;
		seed_value  <= new_seed;
		// payload stays put while the block stalls
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		predict_command(op, limit, new_seed);
	endtask

	// result side back-pressure, random bursts of stall
	initial begin
		int unsigned stall_len;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = receiver_idle_en ? pick_gap() : 0;
			if (stall_len > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (stall_len - 1) @(negedge clk);
			end
			@(negedge clk);
			res_stall <= 1'b0;
		end
	end

	// every result transfer is compared against the oldest owed draw value
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_values.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("[%0t] unexpected result transfer: value=%h", $realtime, value);
			end else begin
				if (value !== expected_values[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("[%0t] value mismatch: expected=%h actual=%h",
							$realtime, expected_values[0], value);
				end
				void'(expected_values.pop_front());
			end
		end
	end

	// seed after reset is zero and stays zero, so every draw gives 0
	task automatic test_zero_seed();
		send_command(CMD_DRAW_INT, 32'd7, 32'h0);
		send_command(CMD_DRAW_FRAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_DRAW_INT, 32'd0, 32'h0);
	endtask

	// load reduction: 2^31-1 loads 0, 2^32-1 and 2^31 load 1, largest legal seed kept
	task automatic test_load_extremes();
		send_command(CMD_LOAD, 32'h0, 32'h7FFF_FFFF);
		send_command(CMD_DRAW_FRAC, 32'h0, 32'h0);
		send_command(CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_DRAW_FRAC, 32'h0, 32'h0);
		send_command(CMD_LOAD, 32'h0, 32'h7FFF_FFFE);
		send_command(CMD_DRAW_INT, 32'hFFFF_FFFF, 32'h0);
		send_command(CMD_LOAD, 32'h0, 32'h8000_0000);
		send_command(CMD_DRAW_FRAC, 32'h0, 32'h0);
	endtask

	// integer draws over the edges of the range field, back to back
	task automatic test_range_extremes();
		sender_idle_en = 1'b0;
		send_command(CMD_LOAD, 32'h0, 32'd12345);
		send_command(CMD_DRAW_INT, 32'd0, 32'h0);
		send_command(CMD_DRAW_INT, 32'd1, 32'h0);
		send_command(CMD_DRAW_INT, 32'd2, 32'h0);
		send_command(CMD_DRAW_INT, 32'hFFFF_FFFF, 32'h0);
		send_command(CMD_DRAW_INT, 32'h8000_0000, 32'h0);
		send_command(CMD_DRAW_INT, 32'h7FFF_FFFF, 32'h0);
		sender_idle_en = 1'b1;
	endtask

	// unused command changes nothing; ignored fields carry all-ones noise
	task automatic test_unused_and_ignored();
		send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_DRAW_FRAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_UNUSED, 32'h0, 32'h0);
		send_command(CMD_DRAW_INT, 32'd1000, 32'hFFFF_FFFF);
		send_command(CMD_LOAD, 32'hFFFF_FFFF, 32'h0000_0001);
		send_command(CMD_DRAW_INT, 32'd0, 32'hFFFF_FFFF);
	endtask

	// range field mix: zero, tiny, powers of two, near the top, anything
	function automatic logic [31:0] pick_range();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 32'd0;
		else if (roll < 35)
			return $urandom_range(1, 16);
		else if (roll < 50)
			return 32'h1 << $urandom_range(0, 31);
		else if (roll < 60)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		return $urandom;
	endfunction

	// mostly draws from a live seed, with reloads and some dropped commands
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned accepted;
		int unsigned iteration;
		int unsigned roll;
		lrg_cmd_t    op;
		logic [31:0] limit;
		logic [31:0] new_seed;
		accepted  = 0;
		iteration = 0;
		while (accepted < n_items) begin
			// new pacing every stretch, including stretches with no idling
			if (iteration % 100 == 0) begin
				sender_idle_en   = ($urandom_range(0, 3) != 0);
				receiver_idle_en = ($urandom_range(0, 3) != 0);
			end
			iteration++;
			roll     = $urandom_range(0, 99);
			limit    = pick_range();
			new_seed = $urandom;
			// a zero seed sticks, so reload before it can starve the draws
			if (lehmer_seed == 31'd0 || roll < 8) begin
				op = CMD_LOAD;
				if ($urandom_range(0, 9) == 0)
					case ($urandom_range(0, 3))
						0:       new_seed = 32'h7FFF_FFFF;
						1:       new_seed = 32'hFFFF_FFFF;
						2:       new_seed = 32'h7FFF_FFFE;
						default: new_seed = 32'h8000_0000;
					endcase
			end else if (roll < 10)
				op = CMD_UNUSED;
			else if (roll < 55)
				op = CMD_DRAW_INT;
			else
				op = CMD_DRAW_FRAC;
			send_command(op, limit, new_seed);
			if (op != CMD_UNUSED)
				accepted++;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cmd_valid        = 1'b0;
		command          = CMD_DRAW_INT;
		range_limit      = '0;
		seed_value       = '0;
		lehmer_seed      = '0;
		mismatch_count   = 0;
		sender_idle_en   = 1'b1;
		receiver_idle_en = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_seed();
		test_load_extremes();
		test_range_extremes();
		test_unused_and_ignored();
		test_random_traffic(850);

		@(negedge clk);
		cmd_valid <= 1'b0;

		// drain: all owed draws back, then room for any stray transfer
		while (expected_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_values.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/lrg_pkg.sv
rtl/lrg_mod_cell.sv
rtl/lrg_seed_unit.sv
rtl/lehmer_random_generator_core.sv
verif/lehmer_random_generator_core_tb.sv
